/* rtl/core/event_interest_table_core_macros.svh */
// Assertion macros used by the event interest table core.
`ifndef EVENT_INTEREST_TABLE_CORE_MACROS_SVH
`define EVENT_INTEREST_TABLE_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define EIT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define EIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/eit_pkg.sv */
// Types, codes and constants of the event interest table.
package eit_pkg;

    localparam int SLOTS_DEF     = 64;
    localparam int DESC_BITS_DEF = 12;

    localparam int DESC_W   = 12;
    localparam int MASK_W   = 32;
    localparam int COOKIE_W = 64;
    localparam int STATUS_W = 3;
    localparam int LIVE_W   = 7;

    localparam logic [MASK_W-1:0] EV_IN  = 32'h0000_0001;
    localparam logic [MASK_W-1:0] EV_OUT = 32'h0000_0004;
    localparam logic [MASK_W-1:0] EV_ERR = 32'h0000_0008;
    localparam logic [MASK_W-1:0] EV_HUP = 32'h0000_0010;
    localparam int EV_ONESHOT_BIT = 30;
    localparam int EV_EDGE_BIT    = 31;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_MOD    = 2'd1,
        OP_DEL    = 2'd2,
        OP_REPORT = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_INVALID = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_EXISTS  = 3'd3,
        STAT_FULL    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]          op;
        logic [DESC_W-1:0]   descriptor;
        logic [MASK_W-1:0]   interest_mask;
        logic [COOKIE_W-1:0] cookie;
        logic [MASK_W-1:0]   readiness;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                reported;
        logic [MASK_W-1:0]   reported_events;
        logic [COOKIE_W-1:0] reported_cookie;
        logic [LIVE_W-1:0]   live_count;
    } t_out_item;

    // Decision of the operation evaluator: result fields plus table updates.
    typedef struct packed {
        t_status             status;
        logic                reported;
        logic [MASK_W-1:0]   events;
        logic [COOKIE_W-1:0] cookie;
        logic                take_slot;
        logic                refresh;
        logic                drop;
        logic                disarm;
        logic [MASK_W-1:0]   new_interest;
    } t_verdict;

endpackage

/* rtl/core/eit_eval.sv */
// Operation evaluator: status, report fields and table update decisions.
module eit_eval import eit_pkg::*; (
    input  t_in_item            i_item,
    input  logic                i_hit,
    input  logic                i_free,
    input  logic [MASK_W-1:0]   i_interest,
    input  logic [COOKIE_W-1:0] i_cookie,
    output t_verdict            o_verdict
);

    logic              edge_req;
    logic [MASK_W-1:0] masked;

    assign edge_req = i_item.interest_mask[EV_EDGE_BIT];
    assign masked   = i_item.readiness & (i_interest | EV_ERR | EV_HUP);

    always_comb begin
        o_verdict              = '0;
        o_verdict.status       = STAT_OK;
        o_verdict.new_interest = i_interest & ~(EV_IN | EV_OUT);
        case (i_item.op)
            OP_ADD: begin
                if (edge_req) begin
                    o_verdict.status = STAT_INVALID;
                end else if (i_hit) begin
                    o_verdict.status = STAT_EXISTS;
                end else if (!i_free) begin
                    o_verdict.status = STAT_FULL;
                end else begin
                    o_verdict.take_slot = 1'b1;
                end
            end
            OP_MOD: begin
                if (edge_req) begin
                    o_verdict.status = STAT_INVALID;
                end else if (!i_hit) begin
                    o_verdict.status = STAT_ABSENT;
                end else begin
                    o_verdict.refresh = 1'b1;
                end
            end
            OP_DEL: begin
                if (!i_hit) begin
                    o_verdict.status = STAT_ABSENT;
                end else begin
                    o_verdict.drop = 1'b1;
                end
            end
            OP_REPORT: begin
                if (!i_hit) begin
                    o_verdict.status = STAT_ABSENT;
                end else if (masked != '0) begin
                    o_verdict.reported = 1'b1;
                    o_verdict.events   = masked;
                    o_verdict.cookie   = i_cookie;
                    o_verdict.disarm   = i_interest[EV_ONESHOT_BIT];
                end
            end
            default: begin
                o_verdict.status = STAT_OK;
            end
        endcase
    end

endmodule

/* rtl/core/event_interest_table_core.sv */
// Event interest table: descriptor registration table with report lookup.
//
//   channel   dir   handshake                 payload
//   --------  ----  ------------------------  ------------------------------
//   input     in    i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   output    out   o_out_valid / i_out_ready o_out_item (t_out_item)
//
// Steps per item: after accept, the scan reads one tag per cycle (the compare
//   works on the registered tag read), the fetch state reads the matched
//   entry's mask and cookie, the exec state evaluates, writes back and registers
//   the result, and then the idle state takes the next item.
// Reset: synchronous, active low; afterwards a clearing pass over all SLOTS entries
//   zeroes the valid bits in the tag memory, with o_in_ready low meanwhile.
// Stalls: the result sits in an output register; a new item is accepted
//   while it waits, and only the final write-back cycle waits for it to go.
// Items are handled one at a time, so memory accesses never overlap.
`include "event_interest_table_core_macros.svh"

module event_interest_table_core import eit_pkg::*; #(
    parameter int SLOTS           = SLOTS_DEF,
    parameter int DESCRIPTOR_BITS = DESC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    // Only the low DESCRIPTOR_BITS (at most 12) of the 12-bit field take part in matching.
    localparam int KEY_W  = (DESCRIPTOR_BITS < DESC_W) ? DESCRIPTOR_BITS : DESC_W;
    localparam int TAG_W  = KEY_W + 1;
    localparam int DATA_W = MASK_W + COOKIE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // Tag memory: {valid, descriptor key}. Data memory: {interest, cookie}.
    logic [TAG_W-1:0]  tag_mem  [SLOTS];
    logic [DATA_W-1:0] data_mem [SLOTS];

    t_state             r_state, n_state;
    t_in_item           r_item;
    logic [IDX_W-1:0]   r_scan_idx;
    logic               r_issue_done;
    logic               r_chk;
    logic [IDX_W-1:0]   r_chk_idx;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid;
    t_out_item          r_out_item;
    logic [TAG_W-1:0]   r_tag_q;
    logic [DATA_W-1:0]  r_data_q;

    logic               accept;
    logic               out_free;
    logic               exec_go;
    logic [KEY_W-1:0]   key;
    logic               tag_re;
    logic               tag_hit;
    logic               tag_free;
    logic               tag_we;
    logic [IDX_W-1:0]   tag_waddr;
    logic [TAG_W-1:0]   tag_wdata;
    logic               data_we;
    logic [IDX_W-1:0]   data_waddr;
    logic [DATA_W-1:0]  data_wdata;
    t_verdict           verdict;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign exec_go     = (r_state == ST_EXEC) && out_free;
    assign key         = r_item.descriptor[KEY_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Scan compare on the registered tag read.
    assign tag_re   = (r_state == ST_SCAN) && !r_issue_done;
    assign tag_hit  = r_chk && r_tag_q[KEY_W] && (r_tag_q[KEY_W-1:0] == key);
    assign tag_free = r_chk && !r_tag_q[KEY_W];

    eit_eval u_eval (
        .i_item     (r_item),
        .i_hit      (r_hit),
        .i_free     (r_free_found),
        .i_interest (r_data_q[DATA_W-1:COOKIE_W]),
        .i_cookie   (r_data_q[COOKIE_W-1:0]),
        .o_verdict  (verdict)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_scan_idx == LAST_IDX) n_state = ST_IDLE;
            ST_IDLE:  if (accept) n_state = ST_SCAN;
            ST_SCAN:  if (r_chk && (r_chk_idx == LAST_IDX)) n_state = ST_FETCH;
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // Memory write controls and live count update.
    always_comb begin
        tag_we     = 1'b0;
        tag_waddr  = r_hit_idx;
        tag_wdata  = {1'b0, key};
        data_we    = 1'b0;
        data_waddr = r_hit_idx;
        data_wdata = {r_item.interest_mask, r_item.cookie};
        n_count    = r_count;
        case (r_state)
            ST_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = r_scan_idx;
                tag_wdata = '0;
            end
            ST_EXEC: begin
                if (exec_go) begin
                    if (verdict.take_slot) begin
                        tag_we     = 1'b1;
                        tag_waddr  = r_free_idx;
                        tag_wdata  = {1'b1, key};
                        data_we    = 1'b1;
                        data_waddr = r_free_idx;
                        n_count    = r_count + CNT_W'(1);
                    end else if (verdict.drop) begin
                        tag_we  = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end else if (verdict.refresh) begin
                        data_we = 1'b1;
                    end else if (verdict.disarm) begin
                        data_we    = 1'b1;
                        data_wdata = {verdict.new_interest, r_data_q[COOKIE_W-1:0]};
                    end
                end
            end
            default: begin
                tag_we = 1'b0;
            end
        endcase
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
        if (tag_re) r_tag_q <= tag_mem[r_scan_idx];
        if (data_we) data_mem[data_waddr] <= data_wdata;
        if (r_state == ST_FETCH) r_data_q <= data_mem[r_hit_idx];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_scan_idx   <= '0;
            r_issue_done <= 1'b0;
            r_chk        <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            // a new result replaces the one leaving in the same cycle
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_scan_idx <= (r_scan_idx == LAST_IDX) ? '0 : r_scan_idx + IDX_W'(1);
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_scan_idx   <= '0;
                        r_issue_done <= 1'b0;
                        r_chk        <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    r_chk <= tag_re;
                    if (tag_re) begin
                        if (r_scan_idx == LAST_IDX) begin
                            r_issue_done <= 1'b1;
                        end else begin
                            r_scan_idx <= r_scan_idx + IDX_W'(1);
                        end
                    end
                    if (tag_hit) r_hit <= 1'b1;
                    if (tag_free) r_free_found <= 1'b1;
                end
                default: begin
                    r_chk <= 1'b0;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) r_item <= i_in_item;
        if (tag_re) r_chk_idx <= r_scan_idx;
        if ((r_state == ST_SCAN) && tag_hit) r_hit_idx <= r_chk_idx;
        if ((r_state == ST_SCAN) && tag_free && !r_free_found) r_free_idx <= r_chk_idx;
        if (exec_go) begin
            r_out_item.status          <= verdict.status;
            r_out_item.reported        <= verdict.reported;
            r_out_item.reported_events <= verdict.events;
            r_out_item.reported_cookie <= verdict.cookie;
            r_out_item.live_count      <= LIVE_W'(n_count);
        end
    end

    `EIT_ASSERT(a_live_bound, r_count <= CNT_W'(SLOTS), "live count above table size")
    `EIT_ASSERT_NEXT(a_accept_scans, i_in_valid && o_in_ready, r_state == ST_SCAN, "accept without scan")
    `EIT_ASSERT_NEXT(a_count_still, r_state != ST_EXEC, $stable(r_count), "count moved outside write-back")
    `EIT_ASSERT_NEXT(a_exec_delivers, exec_go, o_out_valid, "write-back without result")

endmodule
